### hw/rtl/block_to_raster_strip_buffer_macros.svh
// assertion macros for the block to raster strip buffer checker
// no dependencies
`ifndef BLOCK_TO_RASTER_STRIP_BUFFER_MACROS_SVH
`define BLOCK_TO_RASTER_STRIP_BUFFER_MACROS_SVH

// checked only outside reset
`define BTRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BTRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/btrs_pkg.sv
// shared constants for the block to raster strip buffer
// no dependencies
`timescale 1ns / 1ps

package btrs_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int STRIP_ROWS    = 8;
  localparam int SAMPLE_W      = 8;
  localparam int WIDTH_W       = 12;
  localparam int HEIGHT_W      = 16;
  localparam int STRIP_NUM_W   = 13;
  localparam int POS_W         = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(8);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(8);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

### hw/rtl/btrs_stream_if.sv
// valid/ready channels carrying commands in and results out
// depends on btrs_pkg
`timescale 1ns / 1ps

interface btrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [btrs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink (input valid, command, sample, output ready);
endinterface

interface btrs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [btrs_pkg::SAMPLE_W-1:0] pixel;
  logic                          end_of_row;
  logic                          end_of_strip;
  logic                          end_of_image;

  modport source (output valid, accepted, pixel, end_of_row, end_of_strip, end_of_image,
                  input ready);
  modport sink (input valid, accepted, pixel, end_of_row, end_of_strip, end_of_image,
                output ready);
endinterface

### hw/rtl/btrs_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module btrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/block_to_raster_strip_buffer.sv
// pipeline: each accepted item passes the s1 stage, then the output register, before its result is valid
// throughput: one item per cycle while the output is not stalled, set by the single store access per item
// store: one ram of MAX_WIDTH*8 samples, write port for blocks, read port for raster
// reset: synchronous active low, clears counters, strip flag and pipeline valids
// the store is not cleared and holds nothing defined until written
`timescale 1ns / 1ps

module block_to_raster_strip_buffer #(
  parameter int MAX_WIDTH = btrs_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  btrs_in_if.sink                           in_if,
  btrs_out_if.source                        out_if,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [btrs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [btrs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [btrs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DEPTH  = MAX_WIDTH * btrs_pkg::STRIP_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BLK_N  = (MAX_WIDTH + 7) / 8;
  localparam int BLK_W  = (BLK_N > 1) ? $clog2(BLK_N) : 1;
  localparam int SW     = btrs_pkg::SAMPLE_W;
  localparam int WW     = btrs_pkg::WIDTH_W;
  localparam int HW     = btrs_pkg::HEIGHT_W;
  localparam int SNW    = btrs_pkg::STRIP_NUM_W;

  // configuration
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= btrs_pkg::WIDTH_RST;
      height_r <= btrs_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == btrs_pkg::REG_HEIGHT) begin
        height_r <= cfg_pwdata[HW-1:0];
      end else begin
        width_r <= cfg_pwdata[WW-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == btrs_pkg::REG_HEIGHT) begin
      cfg_prdata = btrs_pkg::CFG_DATA_W'(height_r);
    end else begin
      cfg_prdata = btrs_pkg::CFG_DATA_W'(width_r);
    end
  end

  // effective geometry
  logic [31:0] eff_w, eff_h, nblocks, nstrips, base, rows_vis;

  always_comb begin
    eff_w = 32'(width_r);
    if (eff_w == 32'd0) begin
      eff_w = 32'd1;
    end
    if (eff_w > 32'(MAX_WIDTH)) begin
      eff_w = 32'(MAX_WIDTH);
    end
    eff_h = (height_r == '0) ? 32'd1 : 32'(height_r);
    nblocks = (eff_w + 32'd7) >> 3;
    nstrips = (eff_h + 32'd7) >> 3;
  end

  // control state
  logic [BLK_W-1:0] wr_blk_r, wr_blk_nxt;
  logic [5:0]       wr_pos_r, wr_pos_nxt;
  logic [SNW-1:0]   strip_r, strip_nxt;
  logic             ready_r, ready_nxt;
  logic [2:0]       rd_row_r, rd_row_nxt;
  logic [COL_W-1:0] rd_col_r, rd_col_nxt;

  // pipeline
  logic s1_v_r, s1_acc_r, s1_rd_r, s1_eor_r, s1_eos_r, s1_eoi_r;
  logic s1_v_nxt, s1_acc_nxt, s1_rd_nxt, s1_eor_nxt, s1_eos_nxt, s1_eoi_nxt;
  logic          out_v_r, out_acc_r, out_eor_r, out_eos_r, out_eoi_r;
  logic [SW-1:0] out_pix_r;
  logic          out_load, take;
  logic          is_read;

  logic [SW-1:0] ram_rdata;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   wr_col;
  logic          last_strip, eor, eos, eoi;

  assign out_load    = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || out_load;
  assign take        = in_if.valid && in_if.ready;
  assign is_read     = (in_if.command == btrs_pkg::CMD_READ);

  always_comb begin
    wr_col     = 32'(wr_blk_r) * 32'd8 + 32'(wr_pos_r[2:0]);
    last_strip = (32'(strip_r) + 32'd1) >= nstrips;
    base       = 32'(strip_r) * 32'd8;
    if (eff_h > base) begin
      rows_vis = eff_h - base;
      if (rows_vis > 32'd8) begin
        rows_vis = 32'd8;
      end
    end else begin
      rows_vis = 32'd1;
    end
    eor = (32'(rd_col_r) + 32'd1) >= eff_w;
    eos = eor && ((32'(rd_row_r) + 32'd1) >= rows_vis);
    eoi = eos && last_strip;

    ram_waddr = AW'(32'(wr_pos_r[5:3]) * 32'(MAX_WIDTH) + wr_col);
    ram_raddr = AW'(32'(rd_row_r) * 32'(MAX_WIDTH) + 32'(rd_col_r));
    ram_we    = take && !is_read && !ready_r && (wr_col < 32'(MAX_WIDTH));
    ram_re    = take && is_read && ready_r;

    wr_blk_nxt = wr_blk_r;
    wr_pos_nxt = wr_pos_r;
    strip_nxt  = strip_r;
    ready_nxt  = ready_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;

    s1_v_nxt   = s1_v_r && !out_load;
    s1_acc_nxt = s1_acc_r;
    s1_rd_nxt  = s1_rd_r;
    s1_eor_nxt = s1_eor_r;
    s1_eos_nxt = s1_eos_r;
    s1_eoi_nxt = s1_eoi_r;

    if (take) begin
      s1_v_nxt   = 1'b1;
      s1_acc_nxt = 1'b0;
      s1_rd_nxt  = 1'b0;
      s1_eor_nxt = 1'b0;
      s1_eos_nxt = 1'b0;
      s1_eoi_nxt = 1'b0;
      if (!is_read) begin
        if (!ready_r) begin
          s1_acc_nxt = 1'b1;
          if (wr_pos_r == 6'd63) begin
            wr_pos_nxt = '0;
            if ((32'(wr_blk_r) + 32'd1) >= nblocks) begin
              wr_blk_nxt = '0;
              ready_nxt  = 1'b1;
            end else begin
              wr_blk_nxt = wr_blk_r + 1'b1;
            end
          end else begin
            wr_pos_nxt = wr_pos_r + 1'b1;
          end
        end
      end else if (ready_r) begin
        s1_acc_nxt = 1'b1;
        s1_rd_nxt  = 1'b1;
        s1_eor_nxt = eor;
        s1_eos_nxt = eos;
        s1_eoi_nxt = eoi;
        if (eor) begin
          rd_col_nxt = '0;
          if (eos) begin
            rd_row_nxt = '0;
            ready_nxt  = 1'b0;
            strip_nxt  = eoi ? '0 : strip_r + 1'b1;
          end else begin
            rd_row_nxt = rd_row_r + 1'b1;
          end
        end else begin
          rd_col_nxt = rd_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_blk_r <= '0;
      wr_pos_r <= '0;
      strip_r  <= '0;
      ready_r  <= 1'b0;
      rd_row_r <= '0;
      rd_col_r <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      wr_blk_r <= wr_blk_nxt;
      wr_pos_r <= wr_pos_nxt;
      strip_r  <= strip_nxt;
      ready_r  <= ready_nxt;
      rd_row_r <= rd_row_nxt;
      rd_col_r <= rd_col_nxt;
      s1_v_r   <= s1_v_nxt;
      if (out_load) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_acc_r <= s1_acc_nxt;
    s1_rd_r  <= s1_rd_nxt;
    s1_eor_r <= s1_eor_nxt;
    s1_eos_r <= s1_eos_nxt;
    s1_eoi_r <= s1_eoi_nxt;
    if (out_load && s1_v_r) begin
      out_acc_r <= s1_acc_r;
      out_pix_r <= s1_rd_r ? ram_rdata : '0;
      out_eor_r <= s1_eor_r;
      out_eos_r <= s1_eos_r;
      out_eoi_r <= s1_eoi_r;
    end
  end

  btrs_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_if.sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_if.valid        = out_v_r;
  assign out_if.accepted     = out_acc_r;
  assign out_if.pixel        = out_pix_r;
  assign out_if.end_of_row   = out_eor_r;
  assign out_if.end_of_strip = out_eos_r;
  assign out_if.end_of_image = out_eoi_r;

endmodule

### hw/rtl/btrs_checker.sv
// port level checks for the block to raster strip buffer, bound to the top level
// depends on block_to_raster_strip_buffer_macros.svh and btrs_pkg
`timescale 1ns / 1ps
`include "block_to_raster_strip_buffer_macros.svh"

module btrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_accepted,
  input logic [btrs_pkg::SAMPLE_W-1:0] out_pixel,
  input logic                          out_end_of_row,
  input logic                          out_end_of_strip,
  input logic                          out_end_of_image
);

  `BTRS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel) && $stable(out_accepted) && $stable(out_end_of_row)), "stalled result changed")
  `BTRS_ASSERT(a_refused_clean, clk, rst_n, (out_valid && !out_accepted) |-> (out_pixel == '0 && !out_end_of_row && !out_end_of_strip && !out_end_of_image), "refused item carries data")
  `BTRS_ASSERT(a_end_nesting, clk, rst_n, (out_valid && out_end_of_strip) |-> (out_end_of_row && out_accepted), "end of strip without end of row")
  `BTRS_ASSERT(a_eoi_in_strip, clk, rst_n, (out_valid && out_end_of_image) |-> out_end_of_strip, "end of image outside strip end")
  `BTRS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind block_to_raster_strip_buffer btrs_checker u_btrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_accepted     (out_if.accepted),
  .out_pixel        (out_if.pixel),
  .out_end_of_row   (out_if.end_of_row),
  .out_end_of_strip (out_if.end_of_strip),
  .out_end_of_image (out_if.end_of_image)
);

### tb/tb.sv
// testbench for the block to raster strip buffer: a directed table, then random commands
// across several image sizes, each result checked against its table entry or an inline raster predictor
// depends on btrs_pkg, btrs_stream_if and block_to_raster_strip_buffer
`timescale 1ns / 1ps

module tb;

  localparam int MAXW = btrs_pkg::DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MODE_ITEMS = 48;
  localparam int NUM_SETTINGS = 8;
  localparam int NUM_ROWS = 12;

  typedef struct packed {
    logic            accepted;
    logic [7:0]      pixel;
    logic            end_of_row;
    logic            end_of_strip;
    logic            end_of_image;
  } raster_res_t;

  typedef struct packed {
    btrs_pkg::cmd_t  cmd;
    logic [7:0]      smp;
    logic [7:0]      reps;
    logic            typed;
    raster_res_t     res;
  } stim_row_t;

  // sample steps by one per repeat
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{btrs_pkg::CMD_READ,  8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'h00, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'hFF, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'h01, 8'd61, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'h80, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'h55, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_READ,  8'hAA, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_READ,  8'h00, 8'd1,  1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_READ,  8'h00, 8'd61, 1'b0, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_READ,  8'hFF, 8'd1,  1'b1, '{1'b1, 8'h80, 1'b1, 1'b1, 1'b1}},
    '{btrs_pkg::CMD_READ,  8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{btrs_pkg::CMD_WRITE, 8'hFF, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}}
  };

  localparam int SET_W   [NUM_SETTINGS] = '{1, 1, 0, 13, 2048, 4095, 24, 9};
  localparam int SET_H   [NUM_SETTINGS] = '{65535, 1, 0, 19, 65535, 9, 17, 3};
  localparam int SET_N   [NUM_SETTINGS] = '{80, 60, 40, 60, 30, 30, 60, 60};
  localparam bit SET_FIN [NUM_SETTINGS] = '{0, 0, 0, 1, 0, 0, 0, 0};

  localparam int SRC_PCT [4] = '{0, 53, 0, 35};
  localparam int SNK_PCT [4] = '{0, 0, 53, 35};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [btrs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [btrs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [btrs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  btrs_in_if  in_bus ();
  btrs_out_if out_bus ();

  block_to_raster_strip_buffer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [11:0] img_width = 12'd8;
  logic [15:0] img_height = 16'd8;
  logic [7:0]  strip_mem [MAXW*btrs_pkg::STRIP_ROWS];
  int unsigned wr_blk_col = 0;
  logic [5:0]  wr_pos = '0;
  logic [12:0] strip_idx = '0;
  logic        strip_full = 1'b0;
  logic [2:0]  rd_row = '0;
  int unsigned rd_col = 0;

  raster_res_t pending_results [$];
  raster_res_t oldest;
  int mismatches = 0;
  int items_sent = 0;
  int idle_mode = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  function automatic int unsigned vis_width(input logic [11:0] w);
    if (w == 0) return 1;
    if (w > MAXW) return MAXW;
    return w;
  endfunction

  function automatic raster_res_t raster_predict(input btrs_pkg::cmd_t cmd,
                                                 input logic [7:0] smp);
    int unsigned w, h, nblk, nstr, base, rows_vis, col;
    raster_res_t r;
    w = vis_width(img_width);
    h = (img_height == 0) ? 1 : img_height;
    nblk = (w + 7) / 8;
    nstr = (h + 7) / 8;
    r = '0;
    if (cmd == btrs_pkg::CMD_WRITE) begin
      if (!strip_full) begin
        col = wr_blk_col * 8 + wr_pos[2:0];
        if (col < MAXW) strip_mem[wr_pos[5:3] * MAXW + col] = smp;
        r.accepted = 1'b1;
        if (wr_pos == 6'd63) begin
          wr_pos = '0;
          if (wr_blk_col + 1 >= nblk) begin
            wr_blk_col = 0;
            strip_full = 1'b1;
          end else begin
            wr_blk_col++;
          end
        end else begin
          wr_pos++;
        end
      end
    end else if (strip_full) begin
      base = strip_idx * 8;
      if (h > base) rows_vis = (h - base > 8) ? 8 : h - base;
      else rows_vis = 1;
      r.accepted = 1'b1;
      r.pixel = strip_mem[rd_row * MAXW + rd_col];
      r.end_of_row = (rd_col + 1 >= w);
      r.end_of_strip = r.end_of_row && (rd_row + 1 >= rows_vis);
      r.end_of_image = r.end_of_strip && (strip_idx + 1 >= nstr);
      if (r.end_of_row) begin
        rd_col = 0;
        if (r.end_of_strip) begin
          rd_row = '0;
          strip_full = 1'b0;
          strip_idx = r.end_of_image ? '0 : strip_idx + 1'b1;
        end else begin
          rd_row++;
        end
      end else begin
        rd_col++;
      end
    end
    return r;
  endfunction

  task automatic send_cmd(input btrs_pkg::cmd_t cmd, input logic [7:0] smp,
                          input logic typed = 1'b0, input raster_res_t fixed = '0);
    raster_res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.sample <= smp;
    do @(posedge clk); while (!in_bus.ready);
    r = raster_predict(cmd, smp);
    pending_results.push_back(typed ? fixed : r);
    items_sent++;
    if (items_sent % MODE_ITEMS == 0) begin
      idle_mode = (idle_mode + 1) % 4;
      src_idle_pct = SRC_PCT[idle_mode];
      snk_stall_pct = SNK_PCT[idle_mode];
    end
  endtask

  // mostly commands that fit the strip state, some noise
  task automatic random_cmds(input int n);
    btrs_pkg::cmd_t cmd;
    logic [7:0] smp;
    repeat (n) begin
      if ($urandom_range(99) < 85) cmd = strip_full ? btrs_pkg::CMD_READ : btrs_pkg::CMD_WRITE;
      else cmd = btrs_pkg::cmd_t'($urandom_range(1));
      case ($urandom_range(9))
        0: smp = 8'h00;
        1: smp = 8'hFF;
        default: smp = 8'($urandom);
      endcase
      send_cmd(cmd, smp);
    end
  endtask

  // complete the strip in progress and read it out
  task automatic drain_strip();
    while (strip_full || wr_pos != 0 || wr_blk_col != 0)
      send_cmd(strip_full ? btrs_pkg::CMD_READ : btrs_pkg::CMD_WRITE, 8'($urandom));
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input btrs_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= btrs_pkg::CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == btrs_pkg::REG_WIDTH) img_width = val[11:0];
    else img_height = val[15:0];
  endtask

  // a wider image needs a fresh strip, narrower or equal may change mid-strip
  task automatic apply_setting(input logic [31:0] w_val, input logic [31:0] h_val);
    if (vis_width(w_val[11:0]) > vis_width(img_width)) drain_strip();
    settle();
    reg_write(btrs_pkg::REG_WIDTH, w_val);
    reg_write(btrs_pkg::REG_HEIGHT, h_val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting for it");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("accepted", oldest.accepted, out_bus.accepted);
        check_field("pixel", oldest.pixel, out_bus.pixel);
        check_field("end_of_row", oldest.end_of_row, out_bus.end_of_row);
        check_field("end_of_strip", oldest.end_of_strip, out_bus.end_of_strip);
        check_field("end_of_image", oldest.end_of_image, out_bus.end_of_image);
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("block_to_raster_strip_buffer test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = btrs_pkg::CMD_WRITE;
    in_bus.sample = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int i = 0; i < MAXW*btrs_pkg::STRIP_ROWS; i++) strip_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size, one block per strip
    for (int i = 0; i < NUM_ROWS; i++)
      for (int k = 0; k < DIR_ROWS[i].reps; k++)
        send_cmd(DIR_ROWS[i].cmd, DIR_ROWS[i].smp + 8'(k), DIR_ROWS[i].typed,
                 DIR_ROWS[i].res);
    random_cmds(120);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      apply_setting(SET_W[p], SET_H[p]);
      random_cmds(SET_N[p]);
      if (SET_FIN[p]) drain_strip();
    end

    settle();
    if (mismatches == 0) $display("block_to_raster_strip_buffer test passed");
    else $display("block_to_raster_strip_buffer test failed");
    $finish;
  end

endmodule
